FILE: src/pwmda_pkg.sv
// Shared types and constants for the pulse-window metal detector with auto-zeroing.
// No dependencies; used by the interfaces, the core, the output queue and the top level.
package pwmda_pkg;

   // configuration register widths
   localparam int WINDOW_W     = 24;
   localparam int THRESH_W     = 16;
   localparam int QUIET_W      = 26;
   localparam int TIMEOUT_W    = 26;
   localparam int POT_W        = 7;
   localparam int OUTCOME_W    = 2;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 26;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PULSE_THRESH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_QUIET_TICKS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_TIMEOUT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_POT_LIMIT     = 3'd4;

   // register reset values
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 24'd500000;
   localparam logic [THRESH_W-1:0]  THRESH_RESET  = 16'd200;
   localparam logic [QUIET_W-1:0]   QUIET_RESET   = 26'd5000000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 26'd30000000;
   localparam logic [POT_W-1:0]     POT_RESET     = 7'd99;

   // zeroing outcome codes
   localparam logic [OUTCOME_W-1:0] ZERO_NONE      = 2'd0;
   localparam logic [OUTCOME_W-1:0] ZERO_OK        = 2'd1;
   localparam logic [OUTCOME_W-1:0] ZERO_TIMEOUT   = 2'd2;
   localparam logic [OUTCOME_W-1:0] ZERO_POT_LIMIT = 2'd3;

   typedef struct packed {
      logic cmd;
      logic pulse_seen;
   } req_item_type;

   typedef struct packed {
      logic                 metal_present;
      logic [POT_W-1:0]     pot_setting;
      logic                 zero_busy;
      logic [OUTCOME_W-1:0] zero_outcome;
   } rsp_item_type;

endpackage

FILE: src/pwmda_if.sv
// Valid/ready channel interfaces for the detector's input ticks and result items.
// Depends on pwmda_pkg for field widths.
interface pwmda_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic pulse_seen;

   modport source (output valid, output cmd, output pulse_seen, input ready);
   modport sink   (input valid, input cmd, input pulse_seen, output ready);
endinterface

interface pwmda_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            metal_present;
   logic [pwmda_pkg::POT_W-1:0]     pot_setting;
   logic                            zero_busy;
   logic [pwmda_pkg::OUTCOME_W-1:0] zero_outcome;

   modport source (output valid, output metal_present, output pot_setting,
                   output zero_busy, output zero_outcome, input ready);
   modport sink   (input valid, input metal_present, input pot_setting,
                   input zero_busy, input zero_outcome, output ready);
endinterface

FILE: src/pwmda_core.sv
// Detector state, configuration registers and the per-item update logic.
// Depends on pwmda_pkg; instantiated by the top level.
module pwmda_core #(
   parameter int TIME_WIDTH  = 26,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pwmda_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwmda_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              item_accept,
   input  pwmda_pkg::req_item_type           item,
   output pwmda_pkg::rsp_item_type           result
);

   localparam int TC_W = (TIME_WIDTH > pwmda_pkg::QUIET_W) ? TIME_WIDTH : pwmda_pkg::QUIET_W;
   localparam int CC_W = (COUNT_WIDTH > pwmda_pkg::THRESH_W) ? COUNT_WIDTH
                                                              : pwmda_pkg::THRESH_W;
   localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [pwmda_pkg::WINDOW_W-1:0]  window_ticks_ff;
   logic [pwmda_pkg::THRESH_W-1:0]  pulse_threshold_ff;
   logic [pwmda_pkg::QUIET_W-1:0]   quiet_ticks_ff;
   logic [pwmda_pkg::TIMEOUT_W-1:0] zero_timeout_ff;
   logic [pwmda_pkg::POT_W-1:0]     pot_limit_ff;

   logic [COUNT_WIDTH-1:0]          edge_tally_ff, edge_tally_in;
   logic                            window_restart_ff, window_restart_in;
   logic [TIME_WIDTH-1:0]           window_age_ff, window_age_in;
   logic                            detect_flag_ff, detect_flag_in;
   logic                            zeroing_active_ff, zeroing_active_in;
   logic [TIME_WIDTH-1:0]           zero_age_ff, zero_age_in;
   logic [TIME_WIDTH-1:0]           last_hit_age_ff, last_hit_age_in;
   logic [pwmda_pkg::POT_W-1:0]     pot_level_ff, pot_level_in;
   logic [pwmda_pkg::OUTCOME_W-1:0] zero_result_ff, zero_result_in;

   logic [COUNT_WIDTH-1:0] tally_pulse;
   logic [TIME_WIDTH-1:0]  age_chk;
   logic [TIME_WIDTH-1:0]  zero_age_inc;
   logic [TIME_WIDTH-1:0]  quiet_span;
   logic                   window_open;
   logic                   tally_hit;

   assign tally_pulse  = (item.pulse_seen && edge_tally_ff != COUNT_MAX)
                         ? edge_tally_ff + 1'b1 : edge_tally_ff;
   assign age_chk      = window_restart_ff ? '0 : window_age_ff;
   assign window_open  = TC_W'(age_chk) < TC_W'(window_ticks_ff);
   assign tally_hit    = CC_W'(tally_pulse) >= CC_W'(pulse_threshold_ff);
   assign zero_age_inc = (zero_age_ff == TIME_MAX) ? zero_age_ff : zero_age_ff + 1'b1;
   // last hit age never passes zero age, so this never wraps
   assign quiet_span   = zero_age_inc - last_hit_age_ff;

   always_comb begin
      edge_tally_in     = edge_tally_ff;
      window_restart_in = window_restart_ff;
      window_age_in     = window_age_ff;
      detect_flag_in    = detect_flag_ff;
      zeroing_active_in = zeroing_active_ff;
      zero_age_in       = zero_age_ff;
      last_hit_age_in   = last_hit_age_ff;
      pot_level_in      = pot_level_ff;
      zero_result_in    = zero_result_ff;
      if (item_accept) begin
         if (item.cmd) begin
            zeroing_active_in = 1'b1;
            zero_age_in       = '0;
            last_hit_age_in   = '0;
            pot_level_in      = '0;
            zero_result_in    = pwmda_pkg::ZERO_NONE;
         end else begin
            edge_tally_in     = tally_pulse;
            window_restart_in = 1'b0;
            if (!window_open) begin
               detect_flag_in    = 1'b0;
               edge_tally_in     = '0;
               window_restart_in = 1'b1;
            end else if (tally_hit) begin
               detect_flag_in    = 1'b1;
               edge_tally_in     = '0;
               window_restart_in = 1'b1;
            end
            window_age_in = (age_chk == TIME_MAX) ? age_chk : age_chk + 1'b1;
            if (zeroing_active_ff) begin
               zero_age_in = zero_age_inc;
               if (TC_W'(zero_age_inc) > TC_W'(zero_timeout_ff) || zero_age_inc == TIME_MAX) begin
                  zeroing_active_in = 1'b0;
                  zero_result_in    = pwmda_pkg::ZERO_TIMEOUT;
               end else if (TC_W'(quiet_span) > TC_W'(quiet_ticks_ff)) begin
                  zeroing_active_in = 1'b0;
                  zero_result_in    = pwmda_pkg::ZERO_OK;
               end else if (window_open && tally_hit) begin
                  last_hit_age_in = zero_age_inc;
                  if (pot_level_ff >= pot_limit_ff) begin
                     zeroing_active_in = 1'b0;
                     zero_result_in    = pwmda_pkg::ZERO_POT_LIMIT;
                  end else begin
                     pot_level_in = pot_level_ff + 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ticks_ff    <= pwmda_pkg::WINDOW_RESET;
         pulse_threshold_ff <= pwmda_pkg::THRESH_RESET;
         quiet_ticks_ff     <= pwmda_pkg::QUIET_RESET;
         zero_timeout_ff    <= pwmda_pkg::TIMEOUT_RESET;
         pot_limit_ff       <= pwmda_pkg::POT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pwmda_pkg::REG_WINDOW_TICKS: begin
               window_ticks_ff <= csr_wdata[pwmda_pkg::WINDOW_W-1:0];
            end
            pwmda_pkg::REG_PULSE_THRESH: begin
               pulse_threshold_ff <= csr_wdata[pwmda_pkg::THRESH_W-1:0];
            end
            pwmda_pkg::REG_QUIET_TICKS: begin
               quiet_ticks_ff <= csr_wdata[pwmda_pkg::QUIET_W-1:0];
            end
            pwmda_pkg::REG_ZERO_TIMEOUT: begin
               zero_timeout_ff <= csr_wdata[pwmda_pkg::TIMEOUT_W-1:0];
            end
            pwmda_pkg::REG_POT_LIMIT: begin
               pot_limit_ff <= csr_wdata[pwmda_pkg::POT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_tally_ff     <= '0;
         window_restart_ff <= 1'b1;
         window_age_ff     <= '0;
         detect_flag_ff    <= 1'b0;
         zeroing_active_ff <= 1'b0;
         zero_age_ff       <= '0;
         last_hit_age_ff   <= '0;
         pot_level_ff      <= '0;
         zero_result_ff    <= pwmda_pkg::ZERO_NONE;
      end else begin
         edge_tally_ff     <= edge_tally_in;
         window_restart_ff <= window_restart_in;
         window_age_ff     <= window_age_in;
         detect_flag_ff    <= detect_flag_in;
         zeroing_active_ff <= zeroing_active_in;
         zero_age_ff       <= zero_age_in;
         last_hit_age_ff   <= last_hit_age_in;
         pot_level_ff      <= pot_level_in;
         zero_result_ff    <= zero_result_in;
      end
   end

   // result item reports the state after this item's update
   assign result.metal_present = detect_flag_in;
   assign result.pot_setting   = pot_level_in;
   assign result.zero_busy     = zeroing_active_in;
   assign result.zero_outcome  = zero_result_in;

   a_busy_no_outcome: assert property (@(posedge clock) disable iff (reset)
      zeroing_active_ff |-> zero_result_ff == pwmda_pkg::ZERO_NONE)
      else $error("outcome set while zeroing runs");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      item_accept && item.cmd |=> zeroing_active_ff && pot_level_ff == '0)
      else $error("start command did not restart zeroing");

   a_hit_not_past_age: assert property (@(posedge clock) disable iff (reset)
      last_hit_age_ff <= zero_age_ff)
      else $error("last hit age beyond zeroing age");

endmodule

FILE: src/pwmda_out_queue.sv
// Two-entry result buffer between the update logic and the result channel.
// Depends on pwmda_pkg and pwmda_rsp_if.
module pwmda_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pwmda_pkg::rsp_item_type push_item,
   output logic                    has_room,
   pwmda_rsp_if.source             rsp_if
);

   localparam logic [1:0] CNT_EMPTY = 2'd0;
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_FULL  = 2'd2;

   pwmda_pkg::rsp_item_type slot0_ff, slot0_in;
   pwmda_pkg::rsp_item_type slot1_ff, slot1_in;
   logic [1:0]              count_ff, count_in;
   logic                    pop;

   assign pop = (count_ff != CNT_EMPTY) && rsp_if.ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      case (count_ff)
         CNT_EMPTY: begin
            if (push) begin
               slot0_in = push_item;
               count_in = CNT_ONE;
            end
         end
         CNT_ONE: begin
            if (push && pop) begin
               slot0_in = push_item;
            end else if (push) begin
               slot1_in = push_item;
               count_in = CNT_FULL;
            end else if (pop) begin
               count_in = CNT_EMPTY;
            end
         end
         CNT_FULL: begin
            if (pop) begin
               slot0_in = slot1_ff;
               count_in = CNT_ONE;
            end
         end
         default: begin
            count_in = CNT_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_EMPTY;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign has_room             = count_ff != CNT_FULL;
   assign rsp_if.valid         = count_ff != CNT_EMPTY;
   assign rsp_if.metal_present = slot0_ff.metal_present;
   assign rsp_if.pot_setting   = slot0_ff.pot_setting;
   assign rsp_if.zero_busy     = slot0_ff.zero_busy;
   assign rsp_if.zero_outcome  = slot0_ff.zero_outcome;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != CNT_FULL)
      else $error("item pushed into full result buffer");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_FULL && !pop |=> count_ff == CNT_FULL && $stable(slot0_ff))
      else $error("full result buffer changed without a pop");

endmodule

FILE: src/pulse_window_metal_detect_autozero_unit.sv
// Top level of the pulse-window metal detector with auto-zeroing.
// Depends on pwmda_pkg, pwmda_if, pwmda_core and pwmda_out_queue.
//
// One item is taken per clock while the output buffer has room: each tick or start
// command updates the detector state in the same cycle it is accepted, and its result
// item is registered into a two-entry output buffer that drives rsp_if. req_if.ready
// stays high while that buffer has a free entry, so with rsp_if.ready held high the
// block sustains one item per cycle; a stalled consumer fills the buffer after two
// items and then holds off input. Configuration registers are written through
// csr_we/csr_index/csr_wdata and take effect on the next item.
module pulse_window_metal_detect_autozero_unit #(
   parameter int TIME_WIDTH  = 26,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   pwmda_req_if.sink                         req_if,
   pwmda_rsp_if.source                       rsp_if,
   input  logic                              csr_we,
   input  logic [pwmda_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwmda_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pwmda_pkg::req_item_type req_item;
   pwmda_pkg::rsp_item_type rsp_item;
   logic                    has_room;
   logic                    accept;

   assign req_item.cmd        = req_if.cmd;
   assign req_item.pulse_seen = req_if.pulse_seen;
   assign req_if.ready        = has_room;
   assign accept              = req_if.valid && has_room;

   pwmda_core #(
      .TIME_WIDTH  (TIME_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_accept (accept),
      .item        (req_item),
      .result      (rsp_item)
   );

   pwmda_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (rsp_item),
      .has_room  (has_room),
      .rsp_if    (rsp_if)
   );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the pulse-window metal detector with auto-zeroing unit.
// Depends on pwmda_pkg, pwmda_if and the RTL top level; holds its own scoreboard and drivers.

module tb_top;
   import pwmda_pkg::*;

   localparam int TIME_W       = 26;
   localparam int COUNT_W      = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int PRESSURE_AT  = 250;
   localparam int PRESSURE_LEN = 80;

   // Tracks the detector state and the status items it should report.
   class autozero_tracker;
      logic [WINDOW_W-1:0]  win_len;
      logic [THRESH_W-1:0]  hit_count;
      logic [QUIET_W-1:0]   quiet_len;
      logic [TIMEOUT_W-1:0] timeout_len;
      logic [POT_W-1:0]     pot_cap;

      logic [COUNT_W-1:0]   tally;
      bit                   restart;
      logic [TIME_W-1:0]    win_age;
      bit                   metal;
      bit                   busy;
      logic [TIME_W-1:0]    run_age;
      logic [TIME_W-1:0]    hit_age;
      logic [POT_W-1:0]     pot;
      logic [OUTCOME_W-1:0] outcome;

      rsp_item_type pending_status[$];
      int mismatches;
      int checked;
      int runs_ended[4];

      function new();
         win_len     = WINDOW_RESET;
         hit_count   = THRESH_RESET;
         quiet_len   = QUIET_RESET;
         timeout_len = TIMEOUT_RESET;
         pot_cap     = POT_RESET;
         tally       = '0;
         restart     = 1'b1;
         win_age     = '0;
         metal       = 1'b0;
         busy        = 1'b0;
         run_age     = '0;
         hit_age     = '0;
         pot         = '0;
         outcome     = ZERO_NONE;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_WINDOW_TICKS: win_len     = val[WINDOW_W-1:0];
            REG_PULSE_THRESH: hit_count   = val[THRESH_W-1:0];
            REG_QUIET_TICKS:  quiet_len   = val[QUIET_W-1:0];
            REG_ZERO_TIMEOUT: timeout_len = val[TIMEOUT_W-1:0];
            REG_POT_LIMIT:    pot_cap     = val[POT_W-1:0];
            default: ;
         endcase
      endfunction

      // one window check; returns 1 on a fresh detection
      function bit check_window();
         bit hit;
         hit = 1'b0;
         if (restart) begin
            win_age = '0;
            restart = 1'b0;
         end
         if (win_age < win_len) begin
            if (tally >= hit_count) begin
               metal   = 1'b1;
               tally   = '0;
               restart = 1'b1;
               hit     = 1'b1;
            end
         end else begin
            metal   = 1'b0;
            tally   = '0;
            restart = 1'b1;
         end
         if (win_age != '1) win_age = win_age + 1'b1;
         return hit;
      endfunction

      function void end_run(logic [OUTCOME_W-1:0] why);
         busy    = 1'b0;
         outcome = why;
         runs_ended[why]++;
      endfunction

      function void advance_zeroing(bit hit);
         logic [TIME_W-1:0] since_hit;
         if (run_age != '1) run_age = run_age + 1'b1;
         since_hit = run_age - hit_age;
         if (run_age > timeout_len || run_age == '1) begin
            end_run(ZERO_TIMEOUT);
         end else if (since_hit > quiet_len) begin
            end_run(ZERO_OK);
         end else if (hit) begin
            hit_age = run_age;
            if (pot >= pot_cap) end_run(ZERO_POT_LIMIT);
            else pot = pot + 1'b1;
         end
      endfunction

      function void note_tick(req_item_type it);
         rsp_item_type want;
         bit hit;
         if (it.cmd) begin
            busy    = 1'b1;
            run_age = '0;
            hit_age = '0;
            pot     = '0;
            outcome = ZERO_NONE;
         end else begin
            if (it.pulse_seen && tally != '1) tally = tally + 1'b1;
            hit = check_window();
            if (busy) advance_zeroing(hit);
         end
         want.metal_present = metal;
         want.pot_setting   = pot;
         want.zero_busy     = busy;
         want.zero_outcome  = outcome;
         pending_status.push_back(want);
      endfunction

      function void check_status(rsp_item_type got);
         rsp_item_type want;
         checked++;
         if (pending_status.size() == 0) begin
            mismatches++;
            $error("status item arrived with none expected");
            return;
         end
         want = pending_status.pop_front();
         if (want != got) begin
            mismatches++;
            if (want.metal_present != got.metal_present)
               $error("metal_present: expected %0d, got %0d",
                      want.metal_present, got.metal_present);
            if (want.pot_setting != got.pot_setting)
               $error("pot_setting: expected %0d, got %0d", want.pot_setting, got.pot_setting);
            if (want.zero_busy != got.zero_busy)
               $error("zero_busy: expected %0d, got %0d", want.zero_busy, got.zero_busy);
            if (want.zero_outcome != got.zero_outcome)
               $error("zero_outcome: expected %0d, got %0d",
                      want.zero_outcome, got.zero_outcome);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pwmda_req_if req_ch ();
   pwmda_rsp_if rsp_ch ();

   pulse_window_metal_detect_autozero_unit #(
      .TIME_WIDTH  (TIME_W),
      .COUNT_WIDTH (COUNT_W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   autozero_tracker tracker = new();
   int  items_sent;
   int  settings_used;
   bit  sender_idles = 1'b1;
   int  idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap(bit idles);
      int r;
      if (!idles) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_tick(input logic c, input logic p);
      int gap;
      req_item_type it;
      gap = pick_gap(sender_idles);
      it.cmd        = c;
      it.pulse_seen = p;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= c;
      req_ch.pulse_seen <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_tick(it);
      items_sent++;
   endtask

   // each digit is cmd*2 + pulse_seen
   task automatic send_seq(input string s);
      int i;
      int d;
      for (i = 0; i < s.len(); i++) begin
         d = s[i] - "0";
         send_tick(d[1], d[0]);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.pending_status.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_regs(input int w, input int t, input int q, input int z, input int p);
      logic [CSR_INDEX_W-1:0] idx [5];
      logic [CSR_DATA_W-1:0]  val [5];
      int i;
      idx[0] = REG_WINDOW_TICKS;
      idx[1] = REG_PULSE_THRESH;
      idx[2] = REG_QUIET_TICKS;
      idx[3] = REG_ZERO_TIMEOUT;
      idx[4] = REG_POT_LIMIT;
      val[0] = CSR_DATA_W'(w);
      val[1] = CSR_DATA_W'(t);
      val[2] = CSR_DATA_W'(q);
      val[3] = CSR_DATA_W'(z);
      val[4] = CSR_DATA_W'(p);
      for (i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         tracker.write_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic random_ticks(input int n, input int pulse_pct, input int cmd_permil);
      int i;
      logic c;
      logic p;
      for (i = 0; i < n; i++) begin
         c = ($urandom_range(0, 999) < cmd_permil);
         p = ($urandom_range(0, 99) < pulse_pct);
         send_tick(c, p);
      end
   endtask

   // result side: random stalls plus one long hold-off to back up the block
   initial begin
      int run_left;
      int stall_left;
      bit pressed;
      rsp_item_type got;
      run_left   = 0;
      stall_left = 0;
      pressed    = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.metal_present = rsp_ch.metal_present;
            got.pot_setting   = rsp_ch.pot_setting;
            got.zero_busy     = rsp_ch.zero_busy;
            got.zero_outcome  = rsp_ch.zero_outcome;
            tracker.check_status(got);
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            run_left   = $urandom_range(1, 40);
            stall_left = pick_gap(1'b1);
         end
         if (!pressed && tracker.checked >= PRESSURE_AT) begin
            pressed    = 1'b1;
            stall_left = PRESSURE_LEN;
         end
         rsp_ch.ready <= (stall_left == 0);
         @(posedge clock);
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int k;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = 1'b0;
      req_ch.pulse_seen = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: plain ticks, start with a pulse, restart while running
      send_seq("013120");
      drain();
      // detection steps the pot, second hit at the limit, then a quiet success
      set_regs(3, 2, 4, 12, 1);
      send_seq("2110112000000");
      drain();
      // zero threshold and zero pot limit: first check detects and stops zeroing
      set_regs(5, 0, 10, 20, 0);
      send_seq("201");
      drain();

      set_regs(1, 1, 1, 1, 1);
      random_ticks(150, 50, 30);
      drain();
      set_regs(24'hFF_FFFF, 16'hFFFF, 26'h3FF_FFFF, 26'h3FF_FFFF, 127);
      random_ticks(100, 50, 10);
      drain();
      // dense pulses with a tiny window drive the pot all the way up
      set_regs(1, 1, 50, 60000, 127);
      send_tick(1'b1, 1'b0);
      random_ticks(200, 97, 0);
      drain();
      for (k = 0; k < 6; k++) begin
         sender_idles = (k != 2);
         set_regs($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 30),
                  $urandom_range(0, 150), $urandom_range(0, 8));
         random_ticks(140, $urandom_range(20, 90), $urandom_range(5, 40));
         drain();
      end
      repeat (5) @(posedge clock);

      if (tracker.pending_status.size() != 0) begin
         tracker.mismatches++;
         $error("%0d expected status items never arrived", tracker.pending_status.size());
      end
      $display("Ran %0d ticks and commands over %0d register settings, %0d status items checked",
               items_sent, settings_used, tracker.checked);
      $display("Zeroing runs ended: %0d quiet, %0d timeout, %0d pot limit",
               tracker.runs_ended[ZERO_OK], tracker.runs_ended[ZERO_TIMEOUT],
               tracker.runs_ended[ZERO_POT_LIMIT]);
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
